FILE: hdl/assert_macros.svh
// Assertion helpers for the regret-matching table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, off while reset is held.
`define RMT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("regret table check failed");
// Clocked check, also live during reset.
`define RMT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("regret table check failed");
`else
`define RMT_ASSERT(lbl, clk, rst_n, prop)
`define RMT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/rmt_pkg.sv
package rmt_pkg;

  localparam int DEF_MAX_ACTIONS = 8;
  localparam int RESULT_LIMIT    = 8;   // results per read beat

  localparam int CNT_W  = 4;
  localparam int IDX_W  = 3;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 17;
  localparam int REG_W  = 48;
  localparam int POS_W  = REG_W - 1;
  localparam int STR_W  = 40;
  localparam int VIS_W  = 32;
  localparam int PROB_W = 17;
  localparam int FRAC_W = 16;
  // sum of up to eight positive 47-bit regrets
  localparam int SUM_W  = 50;
  // pos * 2^16 + sum / 2
  localparam int NUM_W  = 64;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_REGRET = 2'd1,
    OP_STRAT  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_CLR,
    ST_SUM,
    ST_DLD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        action_index;
    logic signed [VAL_W-1:0] action_value;
    logic signed [VAL_W-1:0] node_ev;
    logic [WGT_W-1:0]        strategy_weight;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic [PROB_W-1:0] probability;
    logic [STR_W-1:0]  strategy_total;
    logic [VIS_W-1:0]  visits;
    logic              status;
    logic              last_result;
  } out_item_t;

  // floor((65536 + n/2) / n)
  function automatic logic [PROB_W-1:0] even_share(input logic [CNT_W-1:0] n);
    logic [PROB_W-1:0] p;
    unique case (n)
      4'd1:    p = 17'd65536;
      4'd2:    p = 17'd32768;
      4'd3:    p = 17'd21845;
      4'd4:    p = 17'd16384;
      4'd5:    p = 17'd13107;
      4'd6:    p = 17'd10923;
      4'd7:    p = 17'd9362;
      4'd8:    p = 17'd8192;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/rmt_ram.sv
module rmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rmt_div.sv
module rmt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rmt_pkg::NUM_W-1:0] num,
  input  logic [rmt_pkg::SUM_W-1:0] den,
  output logic                      done,
  output logic [rmt_pkg::PROB_W-1:0] quo
);
  import rmt_pkg::*;

  localparam int CW = $clog2(PROB_W + 1);

  // restoring division, one quotient bit per cycle; den is held by the caller
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [PROB_W-1:0] low_r, low_nxt;
  logic [PROB_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic              ge;

  always_comb begin
    trial    = {rem_r, low_r[PROB_W-1]};
    diff     = trial - {1'b0, den};
    ge       = trial >= {1'b0, den};
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // quotient fits 17 bits, so the top part is already below den
      rem_nxt  = SUM_W'(num[NUM_W-1:PROB_W]);
      low_nxt  = num[PROB_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      low_nxt = {low_r[PROB_W-2:0], 1'b0};
      quo_nxt = {quo_r[PROB_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(PROB_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hdl/regret_matching_table.sv
// Regret-matching table, one beat at a time: regret and strategy beats each do one
// read-modify-write of a single RAM entry; a clear beat resets valid bits and visits.
// Read beat: sum the positive regrets of the n entries, then per action load the entry,
// run the 17-step serial divider and emit, or skip the divider when all regrets <= 0.
// Synchronous active-low reset clears entry valid bits, visits and sets the
// action count to its limit; no clearing pass, the block is ready right away.
`include "assert_macros.svh"

module regret_matching_table #(
  parameter int MAX_ACTIONS = rmt_pkg::DEF_MAX_ACTIONS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rmt_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rmt_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rmt_pkg::CNT_W-1:0] cfg_data
);
  import rmt_pkg::*;

  localparam int AW   = $clog2(MAX_ACTIONS);
  // effective action limit: the smaller of the table depth and the results per read beat
  localparam int NLIM = (MAX_ACTIONS < RESULT_LIMIT) ? MAX_ACTIONS : RESULT_LIMIT;
  localparam logic [CNT_W-1:0] NLIM_C = CNT_W'(NLIM);

  // ---------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  in_item_t               item_r, item_nxt;
  logic                   bad_r, bad_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [VIS_W-1:0]       visits_r, visits_nxt;
  // entry valid bits: an entry never written since the last clear reads as 0
  logic [MAX_ACTIONS-1:0] rvalid_r, rvalid_nxt;
  logic [MAX_ACTIONS-1:0] svalid_r, svalid_nxt;
  logic [AW-1:0]          raddr_q_r;
  logic [IDX_W-1:0]       k_r, k_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [STR_W-1:0]       strat_r, strat_nxt;
  logic [PROB_W-1:0]      prob_r, prob_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------
  // memories: regret (signed Q32.16) and strategy sum (unsigned Q24.16)
  // ---------------------------------------------------------------------
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             rg_we, st_we;
  logic [REG_W-1:0] rg_wdata, rg_raw, rg_q;
  logic [STR_W-1:0] st_wdata, st_raw, st_q;

  rmt_ram #(.WIDTH(REG_W), .DEPTH(MAX_ACTIONS)) u_regret_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (wr_addr),
    .wdata (rg_wdata),
    .raddr (rd_addr),
    .rdata (rg_raw)
  );

  rmt_ram #(.WIDTH(STR_W), .DEPTH(MAX_ACTIONS)) u_strat_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (wr_addr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_raw)
  );

  // ---------------------------------------------------------------------
  // divider for the read path
  // ---------------------------------------------------------------------
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic              div_done;
  logic [PROB_W-1:0] div_quo;

  rmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sum_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------
  logic              rvld_q, svld_q;
  logic              in_acc, cfg_acc, out_free, out_load, last_k;
  logic [IDX_W-1:0]  k_inc;
  logic [POS_W-1:0]  pos;
  logic [VAL_W:0]    delta;
  logic [REG_W:0]    rsum;
  logic [STR_W:0]    ssum;
  logic [STR_W-1:0]  st_new;
  logic [REG_W-1:0]  rg_new;
  logic [VIS_W-1:0]  vis_upd;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign out_free = !out_valid_r || !out_stall;
  assign k_inc    = k_r + IDX_W'(1);
  assign last_k   = ({1'b0, k_r} == (n_r - CNT_W'(1)));

  // guard the lookup; addresses past the depth only occur for ignored beats
  assign rvld_q = ({1'b0, raddr_q_r} < (AW+1)'(MAX_ACTIONS)) && rvalid_r[raddr_q_r];
  assign svld_q = ({1'b0, raddr_q_r} < (AW+1)'(MAX_ACTIONS)) && svalid_r[raddr_q_r];
  assign rg_q   = rvld_q ? rg_raw : '0;
  assign st_q   = svld_q ? st_raw : '0;

  assign pos = rg_q[REG_W-1] ? '0 : rg_q[POS_W-1:0];

  // regret: 33-bit difference, 49-bit sum, clamp to 48-bit signed
  assign delta = {item_r.action_value[VAL_W-1], item_r.action_value}
               - {item_r.node_ev[VAL_W-1], item_r.node_ev};
  assign rsum  = {rg_q[REG_W-1], rg_q}
               + {{(REG_W-VAL_W){delta[VAL_W]}}, delta};
  always_comb begin
    if (rsum[REG_W] != rsum[REG_W-1]) begin
      rg_new = rsum[REG_W] ? {1'b1, {POS_W{1'b0}}} : {1'b0, {POS_W{1'b1}}};
    end else begin
      rg_new = rsum[REG_W-1:0];
    end
  end

  // strategy sum saturates at all ones
  assign ssum   = {1'b0, st_q} + (STR_W+1)'(item_r.strategy_weight);
  assign st_new = ssum[STR_W] ? '1 : ssum[STR_W-1:0];

  assign vis_upd = (item_r.op == OP_STRAT && item_r.is_last && visits_r != '1)
                 ? visits_r + VIS_W'(1) : visits_r;

  assign div_num = NUM_W'({pos, {FRAC_W{1'b0}}}) + NUM_W'(sum_r[SUM_W-1:1]);

  assign wr_addr  = AW'(item_r.action_index);
  assign rg_wdata = rg_new;
  assign st_wdata = st_new;

  // read address: the beat's entry when taken, then walk 0..n-1
  always_comb begin
    unique case (state_r)
      ST_IDLE: rd_addr = (in_data.op == OP_READ) ? '0 : AW'(in_data.action_index);
      ST_UPD:  rd_addr = AW'(item_r.action_index);
      ST_SUM:  rd_addr = last_k ? '0 : AW'(k_inc);
      ST_EMIT: rd_addr = last_k ? AW'(k_r) : AW'(k_inc);
      ST_CLR, ST_DLD, ST_DIV: rd_addr = AW'(k_r);
      default: rd_addr = AW'(k_r);
    endcase
  end

  // ---------------------------------------------------------------------
  // control: next state, register updates, output load
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    bad_nxt       = bad_r;
    n_nxt         = n_r;
    visits_nxt    = visits_r;
    rvalid_nxt    = rvalid_r;
    svalid_nxt    = svalid_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    strat_nxt     = strat_r;
    prob_nxt      = prob_r;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    rg_we         = 1'b0;
    st_we         = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          bad_nxt  = ({1'b0, in_data.action_index} >= n_r);
          unique case (in_data.op)
            OP_CLEAR: begin
              rvalid_nxt = '0;
              svalid_nxt = '0;
              visits_nxt = '0;
              state_nxt  = ST_CLR;
            end
            OP_READ: begin
              sum_nxt   = '0;
              k_nxt     = '0;
              state_nxt = ST_SUM;
            end
            OP_REGRET, OP_STRAT: begin
              state_nxt = ST_UPD;
            end
          endcase
        end
      end

      ST_UPD: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_data_nxt.out_index     = item_r.action_index;
          out_data_nxt.probability   = '0;
          out_data_nxt.status        = bad_r;
          out_data_nxt.last_result   = 1'b1;
          if (bad_r) begin
            out_data_nxt.strategy_total = '0;
            out_data_nxt.visits         = visits_r;
          end else if (item_r.op == OP_STRAT) begin
            st_we                       = 1'b1;
            svalid_nxt[wr_addr]         = 1'b1;
            visits_nxt                  = vis_upd;
            out_data_nxt.strategy_total = st_new;
            out_data_nxt.visits         = vis_upd;
          end else begin
            rg_we                       = 1'b1;
            rvalid_nxt[wr_addr]         = 1'b1;
            out_data_nxt.strategy_total = st_q;
            out_data_nxt.visits         = visits_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_CLR: begin
        if (out_free) begin
          out_load                    = 1'b1;
          out_data_nxt.out_index      = '0;
          out_data_nxt.probability    = '0;
          out_data_nxt.strategy_total = '0;
          out_data_nxt.visits         = '0;
          out_data_nxt.status         = 1'b0;
          out_data_nxt.last_result    = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end

      ST_SUM: begin
        // read data belongs to entry k_r
        sum_nxt = sum_r + SUM_W'(pos);
        if (last_k) begin
          k_nxt     = '0;
          state_nxt = ST_DLD;
        end else begin
          k_nxt = k_inc;
        end
      end

      ST_DLD: begin
        strat_nxt = st_q;
        if (sum_r == '0) begin
          prob_nxt  = even_share(n_r);
          state_nxt = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          prob_nxt  = div_quo;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load                    = 1'b1;
          out_data_nxt.out_index      = k_r;
          out_data_nxt.probability    = prob_r;
          out_data_nxt.strategy_total = strat_r;
          out_data_nxt.visits         = visits_r;
          out_data_nxt.status         = 1'b0;
          out_data_nxt.last_result    = last_k;
          if (last_k) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_inc;
            state_nxt = ST_DLD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // action count write; zero is dropped, large values clamp, valid bits and visits clear
    if (cfg_acc && cfg_data != '0) begin
      n_nxt      = (cfg_data > NLIM_C) ? NLIM_C : cfg_data;
      rvalid_nxt = '0;
      svalid_nxt = '0;
      visits_nxt = '0;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= NLIM_C;
      visits_r    <= '0;
      rvalid_r    <= '0;
      svalid_r    <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      visits_r    <= visits_nxt;
      rvalid_r    <= rvalid_nxt;
      svalid_r    <= svalid_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    bad_r      <= bad_nxt;
    sum_r      <= sum_nxt;
    strat_r    <= strat_nxt;
    prob_r     <= prob_nxt;
    raddr_q_r  <= rd_addr;
    out_data_r <= out_data_nxt;
  end

  // one beat in flight; reset holds the input side off
  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `RMT_ASSERT(a_accept_leaves_idle, clk, rst_n, in_acc |=> state_r != ST_IDLE)
  `RMT_ASSERT(a_div_done_in_div, clk, rst_n, div_done |-> state_r == ST_DIV)
  `RMT_ASSERT(a_prob_range, clk, rst_n, out_valid_r |-> out_data_r.probability <= 17'd65536)
  `RMT_ASSERT(a_upd_one_write, clk, rst_n, (rg_we || st_we) |-> !(rg_we && st_we) && !bad_r)

endmodule

FILE: tb/tb_regret_matching_table.sv
module tb_regret_matching_table;
  import rmt_pkg::*;

  localparam int N_ACT = DEF_MAX_ACTIONS;
  localparam int IDLE_PCT = 38;
  localparam int RAND_BEATS = 408;
  localparam int RAND_PHASES = 6;
  localparam longint CYCLE_CAP = 3_000_000;
  localparam longint REG_TOP = 64'sh7FFF_FFFF_FFFF;
  localparam longint REG_BOT = -REG_TOP - 1;
  localparam longint unsigned STR_TOP = 64'hFF_FFFF_FFFF;
  localparam longint unsigned VIS_TOP = 64'hFFFF_FFFF;
  localparam longint unsigned Q16_ONE = 64'd65536;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  regret_matching_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table: regrets, strategy sums, visits, action count.
  // ---------------------------------------------------------------------------
  longint          regret_acc [N_ACT];
  longint unsigned strat_acc [N_ACT];
  longint unsigned visit_acc;
  int              act_n;

  out_item_t strategy_rows_due [$];  // result beats still owed by the block
  out_item_t fresh_rows [$];         // beats produced by the latest input beat

  int     fails = 0;
  longint cycles = 0;
  bit     calm = 1'b0;               // no idling on either side while set

  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] count;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic out_item_t row(input int idx, input longint unsigned prob,
                                    input longint unsigned total,
                                    input longint unsigned visits,
                                    input bit status, input bit last);
    out_item_t r;
    r.out_index      = IDX_W'(idx);
    r.probability    = PROB_W'(prob);
    r.strategy_total = STR_W'(total);
    r.visits         = VIS_W'(visits);
    r.status         = status;
    r.last_result    = last;
    return r;
  endfunction

  function automatic in_item_t beat(input op_t op, input int idx, input logic [31:0] av,
                                    input logic [31:0] nv, input int w, input bit last);
    in_item_t it;
    it.op              = op;
    it.action_index    = IDX_W'(idx);
    it.action_value    = av;
    it.node_ev         = nv;
    it.strategy_weight = WGT_W'(w);
    it.is_last         = last;
    return it;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CNT_W-1:0] v);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.count  = v;
    r.item   = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic plan_row_t item_row(input in_item_t it, input bit typed,
                                         input out_item_t want);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.count  = '0;
    r.item   = it;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic void table_clear();
    for (int k = 0; k < N_ACT; k++) begin
      regret_acc[k] = 0;
      strat_acc[k]  = 0;
    end
    visit_acc = 0;
  endfunction

  // Zero is dropped without a clear; anything above the table size saturates.
  function automatic void table_set_count(input logic [CNT_W-1:0] v);
    if (v == 0) return;
    act_n = (int'(v) > N_ACT) ? N_ACT : int'(v);
    table_clear();
  endfunction

  // Regret matching on the shadow table; fills fresh_rows with the beats owed.
  function automatic void match_regrets(input in_item_t it);
    longint unsigned pos_sum;
    longint unsigned pos;
    longint unsigned p;
    longint          acc;
    longint unsigned s;
    int              idx;
    fresh_rows.delete();
    idx = int'(it.action_index);
    if (it.op == OP_CLEAR) begin
      table_clear();
      fresh_rows = {fresh_rows, row(0, 0, 0, 0, 1'b0, 1'b1)};
    end else if (it.op == OP_READ) begin
      pos_sum = 0;
      for (int k = 0; k < act_n; k++)
        if (regret_acc[k] > 0) pos_sum += longint'(regret_acc[k]);
      for (int k = 0; k < act_n; k++) begin
        if (pos_sum == 0) begin
          p = (Q16_ONE + act_n / 2) / act_n;
        end else begin
          pos = (regret_acc[k] > 0) ? regret_acc[k] : 0;
          p = (pos * Q16_ONE + pos_sum / 2) / pos_sum;
        end
        fresh_rows = {fresh_rows, row(k, p, strat_acc[k], visit_acc, 1'b0, k == act_n - 1)};
      end
    end else if (idx >= act_n) begin
      // out-of-range element: nothing changes, not even the visit count
      fresh_rows = {fresh_rows, row(idx, 0, 0, visit_acc, 1'b1, 1'b1)};
    end else begin
      if (it.op == OP_REGRET) begin
        acc = regret_acc[idx] + longint'($signed(it.action_value))
              - longint'($signed(it.node_ev));
        if (acc > REG_TOP) acc = REG_TOP;
        if (acc < REG_BOT) acc = REG_BOT;
        regret_acc[idx] = acc;
      end else begin
        s = strat_acc[idx] + longint'(it.strategy_weight);
        if (s > STR_TOP) s = STR_TOP;
        strat_acc[idx] = s;
        if (it.is_last && visit_acc < VIS_TOP) visit_acc++;
      end
      fresh_rows = {fresh_rows, row(idx, 0, strat_acc[idx], visit_acc, 1'b0, 1'b1)};
    end
  endfunction

  function automatic in_item_t random_beat();
    int          pick;
    logic [31:0] av;
    logic [31:0] nv;
    int          w;
    op_t         op;
    pick = $urandom_range(0, 99);
    if (pick < 4) op = OP_CLEAR;
    else if (pick < 42) op = OP_REGRET;
    else if (pick < 84) op = OP_STRAT;
    else op = OP_READ;
    // full-range values reach the sign bits; small ones keep reads interesting
    if ($urandom_range(0, 1)) begin
      av = $urandom;
      nv = $urandom;
    end else begin
      av = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      nv = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    end
    if ($urandom_range(0, 3) == 0) w = $urandom_range(0, (1 << WGT_W) - 1);
    else w = $urandom_range(0, 65536);
    return beat(op, $urandom_range(0, 7), av, nv, w, $urandom_range(0, 1));
  endfunction

  // Field compare; a mismatch is logged and the run carries on.
  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Random gaps before the beat; valid stays up between back-to-back beats.
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    match_regrets(it);
    if (typed) strategy_rows_due = {strategy_rows_due, want};
    else strategy_rows_due = {strategy_rows_due, fresh_rows};
  endtask

  // Hold off the sender until every owed beat has come back.
  task automatic drain_table();
    in_valid <= 1'b0;
    while (strategy_rows_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    drain_table();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    table_set_count(v);
  endtask

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  out_item_t head;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (strategy_rows_due.size() == 0) begin
        $error("result beat with nothing owed, out_index %0d", out_data.out_index);
        fails++;
      end else begin
        head = strategy_rows_due.pop_front();
        check_field("out_index", head.out_index, out_data.out_index);
        check_field("probability", head.probability, out_data.probability);
        check_field("strategy_total", head.strategy_total, out_data.strategy_total);
        check_field("visits", head.visits, out_data.visits);
        check_field("status", head.status, out_data.status);
        check_field("last_result", head.last_result, out_data.last_result);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t         it;
    logic [CNT_W-1:0] phase_cnt [RAND_PHASES];

    // directed rows; typed expectations only where the answer is obvious
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, item_row(beat(OP_CLEAR, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 (1 << WGT_W) - 1, 1), 1, row(0, 0, 0, 0, 0, 1))};
    plan = {plan, item_row(beat(OP_REGRET, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0),
                            1, row(0, 0, 0, 0, 0, 1))};
    plan = {plan, item_row(beat(OP_REGRET, 7, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0),
                            1, row(7, 0, 0, 0, 0, 1))};
    plan = {plan, item_row(beat(OP_STRAT, 3, 0, 0, 65536, 1),
                            1, row(3, 0, 65536, 1, 0, 1))};
    // weight above one is added as given
    plan = {plan, item_row(beat(OP_STRAT, 3, 0, 0, (1 << WGT_W) - 1, 0),
                            1, row(3, 0, 196607, 1, 0, 1))};
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, item_row(beat(OP_REGRET, 2, 32'h0003_0000, 32'h0001_0000, 0, 0), 0, '0)};
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, cfg_row(4'd3)};
    plan = {plan, item_row(beat(OP_REGRET, 3, 1, 0, 0, 0), 1, row(3, 0, 0, 0, 1, 1))};
    // out of range: is_last must not count a visit
    plan = {plan, item_row(beat(OP_STRAT, 7, 0, 0, 100, 1), 1, row(7, 0, 0, 0, 1, 1))};
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, cfg_row(4'd0)};  // dropped, count stays 3
    plan = {plan, item_row(beat(OP_STRAT, 2, 0, 0, 1, 1), 1, row(2, 0, 1, 1, 0, 1))};
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, cfg_row(4'd15)};  // saturates to full table
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, cfg_row(4'd1)};
    plan = {plan, item_row(beat(OP_STRAT, 0, 0, 0, 65536, 1),
                            1, row(0, 0, 65536, 1, 0, 1))};
    plan = {plan, item_row(beat(OP_STRAT, 1, 0, 0, 65536, 1), 1, row(1, 0, 0, 1, 1, 1))};
    plan = {plan, item_row(beat(OP_REGRET, 0, 0, 1, 0, 0), 1, row(0, 0, 65536, 1, 0, 1))};
    plan = {plan, item_row(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0)};
    plan = {plan, cfg_row(4'd8)};
    plan = {plan, item_row(beat(OP_CLEAR, 0, 0, 0, 0, 0), 1, row(0, 0, 0, 0, 0, 1))};

    phase_cnt[0] = 4'd8;
    phase_cnt[1] = 4'd1;
    phase_cnt[2] = 4'd15;
    phase_cnt[3] = 4'd0;
    phase_cnt[4] = 4'd2;
    phase_cnt[5] = CNT_W'($urandom_range(0, 15));

    act_n = N_ACT;
    table_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_count(plan[i].count);
      else send_beat(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Back-to-back stretch: full-scale swings on action 0 against a small
    // positive regret on action 1, read back after each run.
    calm = 1'b1;
    send_beat(beat(OP_REGRET, 1, 32'h0001_0000, 0, 0, 0), 0, '0);
    repeat (12) send_beat(beat(OP_REGRET, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0), 0, '0);
    send_beat(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0);
    repeat (24) send_beat(beat(OP_REGRET, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 0, '0);
    send_beat(beat(OP_READ, 0, 0, 0, 0, 0), 0, '0);
    calm = 1'b0;

    // random phases, each under its own action count
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_count(phase_cnt[ph]);
      for (int b = 0; b < RAND_BEATS / RAND_PHASES; b++) begin
        it = random_beat();
        send_beat(it, 0, '0);
      end
    end

    drain_table();
    repeat (200) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rmt_pkg.sv
hdl/rmt_ram.sv
hdl/rmt_div.sv
hdl/regret_matching_table.sv
tb/tb_regret_matching_table.sv
